// File: src/wrp_pkg.sv
package wrp_pkg;

    // Work RAM geometry
    localparam int unsigned RAM_BYTES = 131072;
    localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Bus cycle counts
    localparam logic [3:0] CYC_FAST  = 4'd6;
    localparam logic [3:0] CYC_SLOW  = 4'd8;
    localparam logic [3:0] CYC_XSLOW = 4'd12;

    // Fill pattern after reset
    localparam logic [7:0] FILL_EVEN = 8'h55;
    localparam logic [7:0] FILL_ODD  = 8'hAA;

    // Decode constants
    localparam logic [23:0] IO_MASK    = 24'h40FC00;
    localparam logic [23:0] IO_MATCH   = 24'h004000;
    localparam logic [23:0] ROM_MASK   = 24'h408000;
    localparam logic [15:0] OFF_BIAS_A = 16'h6000;
    localparam logic [15:0] OFF_BIAS_B = 16'h4000;
    localparam logic [15:0] OFF_MASK_A = 16'h4000;
    localparam logic [15:0] OFF_MASK_B = 16'h7E00;
    localparam logic [6:0]  WRAM_BANK  = 7'h3F;   // banks 7E and 7F
    localparam logic [15:0] PORT_DATA  = 16'h2180;
    localparam logic [15:0] PORT_ADDL  = 16'h2181;
    localparam logic [15:0] PORT_ADDM  = 16'h2182;
    localparam logic [15:0] PORT_ADDH  = 16'h2183;

    // Input word
    typedef struct packed {
        logic        command;
        logic [23:0] address;
        logic [7:0]  write_data;
    } t_wrp_in;

    // Result word
    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] bus_cycles;
    } t_wrp_out;

    // Request into the work RAM
    typedef struct packed {
        logic              we;
        logic              re;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_ram_req;

    // Item held while the RAM read completes
    typedef struct packed {
        logic       is_write;
        logic       is_ram;
        logic       is_io;
        logic [7:0] write_data;
        logic [3:0] bus_cycles;
    } t_wrp_s1;

endpackage

// File: src/wrp_ram.sv
module wrp_ram (
    input  logic              i_clk,
    input  wrp_pkg::t_ram_req i_req,
    output logic [7:0]        o_rdata
);
    import wrp_pkg::*;

    logic [7:0] r_mem [RAM_BYTES];
    logic [7:0] r_rdata;

    // Single port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/work_ram_port_with_bus_timing.sv
// An accepted word waits in stage 1, then moves to the output register.
// Throughput: one word per cycle unless the output stalls or the fill runs,
// bounded by the single work RAM port. Reset: i_rst_n is synchronous and active
// low; it clears the port address, latches and fast_rom, then a fill pass writes
// 55/AA into all 131072 RAM bytes, one per cycle; o_in_ready is low meanwhile.
module work_ram_port_with_bus_timing (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wrp_pkg::t_wrp_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output wrp_pkg::t_wrp_out o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata
);
    import wrp_pkg::*;

    logic              r_fast_rom;
    logic              r_clearing;
    logic [RAM_AW-1:0] r_clr_idx;
    logic [RAM_AW-1:0] r_port_addr, n_port_addr;
    logic [7:0]        r_bus_latch, r_io_latch;
    logic              r_s1_v;
    t_wrp_s1           r_s1, n_s1;
    logic              r_out_v;
    t_wrp_out          r_out;

    t_ram_req          ram_req;
    logic [7:0]        ram_rdata;
    logic              in_acc, s1_adv;
    logic [7:0]        bank;
    logic [15:0]       off;
    logic              low_bank, is_wbank, is_mirror;
    logic              is_data, is_addl, is_addm, is_addh;
    logic [15:0]       sum_a, sum_b;
    logic [7:0]        s1_rd;

    // Handshake
    assign s1_adv     = r_s1_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_clearing && (!r_s1_v || s1_adv);
    assign in_acc     = i_in_valid && o_in_ready;

    // Address decode
    assign bank      = i_in.address[23:16];
    assign off       = i_in.address[15:0];
    assign low_bank  = !bank[6];
    assign is_wbank  = (bank[7:1] == WRAM_BANK);
    assign is_mirror = low_bank && (off[15:13] == 3'd0);
    assign is_data   = low_bank && (off == PORT_DATA);
    assign is_addl   = low_bank && (off == PORT_ADDL);
    assign is_addm   = low_bank && (off == PORT_ADDM);
    assign is_addh   = low_bank && (off == PORT_ADDH);
    assign sum_a     = off + OFF_BIAS_A;
    assign sum_b     = off - OFF_BIAS_B;

    // RAM request, stage 1 word, port address update
    always_comb begin
        ram_req          = '0;
        ram_req.wdata    = i_in.write_data;
        n_port_addr      = r_port_addr;
        n_s1.is_write    = (i_in.command == CMD_WRITE);
        n_s1.is_ram      = 1'b0;
        n_s1.is_io       = ((i_in.address & IO_MASK) == IO_MATCH);
        n_s1.write_data  = i_in.write_data;

        // bus timing
        if ((i_in.address & ROM_MASK) != '0) begin
            n_s1.bus_cycles = (i_in.address[23] && r_fast_rom) ? CYC_FAST : CYC_SLOW;
        end else if ((sum_a & OFF_MASK_A) != '0) begin
            n_s1.bus_cycles = CYC_SLOW;
        end else if ((sum_b & OFF_MASK_B) != '0) begin
            n_s1.bus_cycles = CYC_FAST;
        end else begin
            n_s1.bus_cycles = CYC_XSLOW;
        end

        // which RAM byte, if any
        if (is_wbank) begin
            n_s1.is_ram  = 1'b1;
            ram_req.addr = RAM_AW'({bank[0], off});
        end else if (is_mirror) begin
            n_s1.is_ram  = 1'b1;
            ram_req.addr = RAM_AW'(off[12:0]);
        end else if (is_data) begin
            n_s1.is_ram  = 1'b1;
            ram_req.addr = r_port_addr;
            if (in_acc) begin
                n_port_addr = r_port_addr + 1'b1;
            end
        end

        // port address byte writes
        if (in_acc && n_s1.is_write) begin
            if (is_addl) begin
                n_port_addr[7:0] = i_in.write_data;
            end else if (is_addm) begin
                n_port_addr[15:8] = i_in.write_data;
            end else if (is_addh) begin
                n_port_addr[16] = i_in.write_data[0];
            end
        end

        ram_req.we = in_acc && n_s1.is_ram && n_s1.is_write;
        ram_req.re = in_acc && n_s1.is_ram && !n_s1.is_write;

        // fill pass owns the port
        if (r_clearing) begin
            ram_req.we    = 1'b1;
            ram_req.re    = 1'b0;
            ram_req.addr  = r_clr_idx;
            ram_req.wdata = r_clr_idx[0] ? FILL_ODD : FILL_EVEN;
        end
    end

    wrp_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // Returned byte: RAM data, I/O latch or open-bus latch, zero on writes
    always_comb begin
        if (r_s1.is_write) begin
            s1_rd = 8'd0;
        end else if (r_s1.is_ram) begin
            s1_rd = ram_rdata;
        end else if (r_s1.is_io) begin
            s1_rd = r_io_latch;
        end else begin
            s1_rd = r_bus_latch;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_rom  <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_port_addr <= '0;
            r_bus_latch <= 8'd0;
            r_io_latch  <= 8'd0;
            r_s1_v      <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fast_rom <= i_cfg_wdata;
            end
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == RAM_AW'(RAM_BYTES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_port_addr <= n_port_addr;
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_out_v <= 1'b1;
                // latch update in item order
                if (r_s1.is_write) begin
                    r_bus_latch <= r_s1.write_data;
                end else if (r_s1.is_io) begin
                    r_io_latch <= s1_rd;
                end else begin
                    r_bus_latch <= s1_rd;
                end
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out.read_data  <= s1_rd;
            r_out.bus_cycles <= r_s1.bus_cycles;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // No words taken while the fill pass runs
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_in_ready)
        else $error("word accepted during RAM fill");

    // A stage 1 advance always lands a result
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_v)
        else $error("stage 1 advance lost");

    // Data port access steps the port address
    a_port_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_data) |=> (r_port_addr == RAM_AW'($past(r_port_addr) + 1'b1)))
        else $error("port address did not increment");

    // Written words return zero
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1.is_write) |=> (r_out.read_data == 8'd0))
        else $error("write returned nonzero data");

endmodule

// File: tb/work_ram_port_with_bus_timing_tb.sv
module work_ram_port_with_bus_timing_tb;
    import wrp_pkg::*;

    localparam int unsigned STALL_LIMIT = 400000;  // covers the RAM fill after reset
    localparam int unsigned SETTLE      = 4;

    // Address decode of the bus map
    localparam logic [23:0] IO_SEL     = 24'h40FC00;
    localparam logic [23:0] IO_HIT     = 24'h004000;
    localparam logic [23:0] ROM_SEL    = 24'h408000;
    localparam logic [15:0] MIRROR_TOP = 16'h1FFF;
    localparam logic [15:0] WP_DATA    = 16'h2180;
    localparam logic [15:0] WP_LOW     = 16'h2181;
    localparam logic [15:0] WP_MID     = 16'h2182;
    localparam logic [15:0] WP_HIGH    = 16'h2183;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_wrp_in  i_in        = '0;
    logic     i_out_ready = 1'b0;
    logic     i_cfg_we    = 1'b0;
    logic     i_cfg_wdata = 1'b0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_wrp_out o_out;

    work_ram_port_with_bus_timing dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block state
    logic [7:0]        wram_shadow [0:RAM_BYTES-1];
    logic [RAM_AW-1:0] port_ptr;
    logic [7:0]        main_latch;
    logic [7:0]        io_latch;
    logic              fast_rom_shadow;

    t_wrp_in     pending_words[$];
    t_wrp_out    expected_results[$];
    int unsigned n_queued   = 0;
    int unsigned n_errors   = 0;
    int unsigned in_gap     = 0;
    int unsigned out_gap    = 0;
    int unsigned quiet_cycs = 0;
    bit          stalls_on  = 1'b1;

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch: %s got %0h want %0h", what, got, want);
        n_errors++;
    endtask

    // Cycle count by region and fast-ROM setting
    function automatic logic [3:0] access_cycles(logic [23:0] a);
        if ((a & ROM_SEL) != 24'h0)
            return (a[23] && fast_rom_shadow) ? CYC_FAST : CYC_SLOW;
        if (((a + 24'h006000) & 24'h004000) != 24'h0)
            return CYC_SLOW;
        if (((a - 24'h004000) & 24'h007E00) != 24'h0)
            return CYC_FAST;
        return CYC_XSLOW;
    endfunction

    // Apply one bus access to the shadow state, return the expected result
    function automatic t_wrp_out bus_access(t_wrp_in w);
        t_wrp_out   r;
        logic [7:0]  bank;
        logic [15:0] off;
        logic        wram_bank;
        logic        low_bank;
        logic        in_io;
        logic [7:0]  rd;
        bank      = w.address[23:16];
        off       = w.address[15:0];
        wram_bank = (bank[7:1] == 7'h3F);
        low_bank  = !bank[6];
        in_io     = (w.address & IO_SEL) == IO_HIT;
        rd        = 8'h00;
        if (w.command == CMD_WRITE) begin
            if (wram_bank) begin
                wram_shadow[{bank[0], off}] = w.write_data;
            end else if (low_bank && off <= MIRROR_TOP) begin
                wram_shadow[{4'h0, off[12:0]}] = w.write_data;
            end else if (low_bank && off == WP_DATA) begin
                wram_shadow[port_ptr] = w.write_data;
                port_ptr = port_ptr + 1'b1;
            end else if (low_bank && off == WP_LOW) begin
                port_ptr[7:0] = w.write_data;
            end else if (low_bank && off == WP_MID) begin
                port_ptr[15:8] = w.write_data;
            end else if (low_bank && off == WP_HIGH) begin
                port_ptr[16] = w.write_data[0];
            end
            main_latch = w.write_data;
        end else begin
            if (wram_bank) begin
                rd = wram_shadow[{bank[0], off}];
            end else if (low_bank && off <= MIRROR_TOP) begin
                rd = wram_shadow[{4'h0, off[12:0]}];
            end else if (low_bank && off == WP_DATA) begin
                rd = wram_shadow[port_ptr];
                port_ptr = port_ptr + 1'b1;
            end else begin
                rd = in_io ? io_latch : main_latch;
            end
            if (in_io)
                io_latch = rd;
            else
                main_latch = rd;
        end
        r.read_data  = rd;
        r.bus_cycles = access_cycles(w.address);
        return r;
    endfunction

    task automatic put_word(logic cmd, logic [23:0] a, logic [7:0] d);
        t_wrp_in w;
        w.command    = cmd;
        w.address    = a;
        w.write_data = d;
        pending_words.push_back(w);
        n_queued++;
    endtask

    // Bank 00-3F or 80-BF
    function automatic logic [7:0] low_bank_pick();
        logic [7:0] b;
        b    = 8'($urandom);
        b[6] = 1'b0;
        return b;
    endfunction

    function automatic logic [15:0] window_offset();
        case ($urandom_range(0, 2))
            0: return {8'h00, 8'($urandom)};
            1: return {8'hFF, 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic any_cmd();
        return $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
    endfunction

    task automatic queue_directed();
        // fill pattern, top of RAM, bank 7F
        put_word(CMD_READ,  24'h7E0000, 8'h00);
        put_word(CMD_READ,  24'h7FFFFF, 8'h00);
        put_word(CMD_WRITE, 24'h7FFFFF, 8'hFF);
        put_word(CMD_READ,  24'h7FFFFF, 8'h00);
        // low mirror in both bank halves
        put_word(CMD_WRITE, 24'hBF1FFF, 8'h5A);
        put_word(CMD_READ,  24'h7E1FFF, 8'h00);
        put_word(CMD_READ,  24'h001FFF, 8'h00);
        // port pointer at the top, then wrap to zero
        put_word(CMD_WRITE, 24'h002181, 8'hFF);
        put_word(CMD_WRITE, 24'h802182, 8'hFF);
        put_word(CMD_WRITE, 24'h3F2183, 8'hFF);
        put_word(CMD_WRITE, 24'h002180, 8'hC3);
        put_word(CMD_READ,  24'h802180, 8'h00);
        put_word(CMD_READ,  24'h7FFFFF, 8'h00);
        // address bytes read as open bus
        put_word(CMD_READ,  24'h002181, 8'h00);
        put_word(CMD_READ,  24'h002183, 8'h00);
        // open bus, I/O latch and timing regions
        put_word(CMD_READ,  24'h004016, 8'h00);
        put_word(CMD_WRITE, 24'h004016, 8'hA5);
        put_word(CMD_READ,  24'h004017, 8'h00);
        put_word(CMD_READ,  24'h004200, 8'h00);
        put_word(CMD_WRITE, 24'h402180, 8'h3C);
        put_word(CMD_READ,  24'hC00000, 8'h00);
        put_word(CMD_READ,  24'h808000, 8'h00);
        put_word(CMD_READ,  24'h008000, 8'h00);
        put_word(CMD_READ,  24'hFFFFFF, 8'h00);
        put_word(CMD_READ,  24'h002100, 8'h00);
    endtask

    task automatic queue_random(int unsigned count);
        int unsigned target;
        int unsigned n;
        logic [15:0] edges [0:11];
        edges = '{16'h1FFF, 16'h2000, 16'h217F, 16'h2184, 16'h3FFF, 16'h4000,
                  16'h43FF, 16'h4400, 16'h5FFF, 16'h6000, 16'h7FFF, 16'h8000};
        target = n_queued + count;
        while (n_queued < target) begin
            case ($urandom_range(0, 9))
                // port setup then a run of data-byte accesses
                0, 1, 2: begin
                    if ($urandom_range(0, 4) == 0) begin
                        put_word(CMD_WRITE, {low_bank_pick(), WP_LOW}, 8'hF0 | 8'($urandom));
                        put_word(CMD_WRITE, {low_bank_pick(), WP_MID}, 8'hFF);
                        put_word(CMD_WRITE, {low_bank_pick(), WP_HIGH}, 8'($urandom) | 8'h01);
                    end else begin
                        if ($urandom_range(0, 4) != 0)
                            put_word(CMD_WRITE, {low_bank_pick(), WP_LOW}, 8'($urandom));
                        if ($urandom_range(0, 4) != 0)
                            put_word(CMD_WRITE, {low_bank_pick(), WP_MID},
                                     $urandom_range(0, 1) ? 8'h00 : 8'($urandom));
                        if ($urandom_range(0, 4) != 0)
                            put_word(CMD_WRITE, {low_bank_pick(), WP_HIGH}, 8'($urandom));
                    end
                    n = $urandom_range(2, 8);
                    repeat (n) put_word(any_cmd(), {low_bank_pick(), WP_DATA}, 8'($urandom));
                    if ($urandom_range(0, 3) == 0)
                        put_word(CMD_READ, {low_bank_pick(), 14'h0860, 2'($urandom)}, 8'h00);
                end
                // full RAM banks
                3, 4: put_word(any_cmd(), {7'h3F, 1'($urandom), window_offset()},
                               8'($urandom));
                // low mirror
                5: put_word(any_cmd(), {low_bank_pick(),
                            $urandom_range(0, 1) ? {8'h00, 8'($urandom)} :
                                                   {3'b000, 13'($urandom)}},
                            8'($urandom));
                // CPU I/O region
                6: put_word(any_cmd(), {low_bank_pick(), 6'b010000, 10'($urandom)},
                            8'($urandom));
                // decode edges
                7: put_word(any_cmd(), {8'($urandom), edges[$urandom_range(0, 11)]},
                            8'($urandom));
                default: put_word(any_cmd(), 24'($urandom), 8'($urandom));
            endcase
        end
    endtask

    task automatic write_fast_rom(logic v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        fast_rom_shadow = v;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Stimulus sequence
    initial begin
        for (int i = 0; i < RAM_BYTES; i++)
            wram_shadow[i] = i[0] ? FILL_ODD : FILL_EVEN;
        port_ptr        = '0;
        main_latch      = 8'h00;
        io_latch        = 8'h00;
        fast_rom_shadow = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        drain();
        write_fast_rom(1'b1);
        queue_random(340);
        drain();
        write_fast_rom(1'b0);
        queue_random(340);
        drain();
        write_fast_rom(1'b1);
        stalls_on = 1'b0;
        queue_random(340);
        drain();

        if (n_errors == 0)
            $display("work_ram_port_with_bus_timing_tb: done, clean");
        else
            $display("work_ram_port_with_bus_timing_tb: done, errors");
        $finish;
    end

    // Input driver with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (in_gap != 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                in_gap     <= $urandom_range(0, 6);
                i_in_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                i_in       <= pending_words.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result sink with random stalls
    always @(posedge i_clk) begin
        if (out_gap != 0) begin
            out_gap     <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            out_gap     <= $urandom_range(0, 6);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: check results, then predict newly accepted words
    always @(posedge i_clk) begin
        t_wrp_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'(o_out), 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out.read_data !== want.read_data)
                        report_mismatch("read_data", 32'(o_out.read_data),
                                        32'(want.read_data));
                    if (o_out.bus_cycles !== want.bus_cycles)
                        report_mismatch("bus_cycles", 32'(o_out.bus_cycles),
                                        32'(want.bus_cycles));
                end
            end
            if (i_in_valid && o_in_ready)
                expected_results.push_back(bus_access(i_in));
        end
    end

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycs <= 0;
        else
            quiet_cycs <= quiet_cycs + 1;
        if (quiet_cycs == STALL_LIMIT) begin
            $display("no handshake for %0d cycles", STALL_LIMIT);
            $display("work_ram_port_with_bus_timing_tb: done, errors");
            $finish;
        end
    end

endmodule
